@@ hdl/mrad_pkg.sv @@
`timescale 1ns / 1ps

package mrad_pkg;

    // Matrix geometry and data width
    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int VALUE_BITS = 32;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W     = $clog2(DEPTH);

    // Register port
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT    = 2'd0,
        REG_COLUMN_COUNT = 2'd1
    } reg_index_t;

    // Stream payload widths
    localparam int FUNC_W      = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    // Item kinds carried on tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD      = 2'd0,
        FUNC_RANGE_ADD = 2'd1,
        FUNC_READ      = 2'd2
    } func_t;

    // Four corners per rectangle update
    localparam int CORNERS = 4;
    localparam int STEP_W  = $clog2(CORNERS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_READ_CUR,
        ST_READ_UP,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    // Row-major address of a cell
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
    endfunction

    // Clamp a written count into 1..maxv
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] value,
                                                     input logic [CNT_W-1:0] maxv);
        if (value == '0)
            clamp_count = CNT_W'(1);
        else if (value > maxv)
            clamp_count = maxv;
        else
            clamp_count = value;
    endfunction

endpackage

@@ hdl/mrad_ram.sv @@
`timescale 1ns / 1ps

module mrad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/matrix_range_add_difference_core.sv @@
`timescale 1ns / 1ps

// Matrix with rectangle range-add, held as a 2D difference store in one RAM.
// Input stream (s_*): tuser is the item kind (load cell, add to rectangle,
// read next cell); tdata carries coordinates and the amount. Output stream
// (m_*): one transaction per read item, tdata = value, row, column; tlast
// marks the final cell of the configured matrix.
// Register port (cfg_*): index 0 row count, index 1 column count, clamped to
// 1..64; writes are ignored while a read pass is under way.
// Flow: an input is taken only in the idle state. A valid load or range add
// outside a read pass holds the block while its four corners are pipelined
// read-modify-writes on the single RAM read port, the last write after the
// last read. A read item captures the current and upper cells from RAM, then
// sums, writes back and emits. Other items and refused updates are dropped.
// Reset and the final cell of a read pass both start a clearing sweep over
// all 4096 RAM words, one word per cycle, during which no input is taken.
// The output register holds a result while the receiver stalls; the next
// input is still taken, and a following read waits to emit until the
// register is free.

module matrix_range_add_difference_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // tuser: func[1:0]
    input  logic [mrad_pkg::FUNC_W-1:0]        s_tuser,
    // tdata: top_row[5:0], left_col[11:6], bottom_row[17:12], right_col[23:18],
    //        amount[55:24]
    input  logic [mrad_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: cell_value[31:0], out_row[37:32], out_col[43:38], zero[47:44]
    output logic [mrad_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mrad_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrad_pkg::CNT_W-1:0]         cfg_data
);

    import mrad_pkg::*;

    // Input fields
    logic [ROW_W-1:0]      in_top_row;
    logic [COL_W-1:0]      in_left_col;
    logic [ROW_W-1:0]      in_bottom_row;
    logic [COL_W-1:0]      in_right_col;
    logic [VALUE_BITS-1:0] in_amount;

    assign in_top_row    = s_tdata[5:0];
    assign in_left_col   = s_tdata[11:6];
    assign in_bottom_row = s_tdata[17:12];
    assign in_right_col  = s_tdata[23:18];
    assign in_amount     = s_tdata[55:24];

    // Control and payload registers
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      row_count_reg, row_count_next;
    logic [CNT_W-1:0]      column_count_reg, column_count_next;
    logic [ROW_W-1:0]      read_row_reg, read_row_next;
    logic [COL_W-1:0]      read_col_reg, read_col_next;
    logic                  reading_reg, reading_next;
    logic [VALUE_BITS-1:0] left_prefix_reg, left_prefix_next;
    logic [VALUE_BITS-1:0] upper_left_reg, upper_left_next;
    logic [VALUE_BITS-1:0] cur_reg, cur_next;
    logic [VALUE_BITS-1:0] up_reg, up_next;
    logic [CNT_W-1:0]      r_lo_reg, r_lo_next;
    logic [CNT_W-1:0]      r_hi_reg, r_hi_next;
    logic [CNT_W-1:0]      c_lo_reg, c_lo_next;
    logic [CNT_W-1:0]      c_hi_reg, c_hi_next;
    logic [VALUE_BITS-1:0] amount_reg, amount_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  wr_en_reg, wr_en_next;
    logic [ADDR_W-1:0]     wr_addr_reg, wr_addr_next;
    logic [VALUE_BITS-1:0] wr_delta_reg, wr_delta_next;
    logic [ADDR_W-1:0]     clr_reg, clr_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic                  out_last_reg, out_last_next;

    // RAM port signals
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    mrad_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_diff_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Corner selected by the update step
    logic [CNT_W-1:0]      corner_row;
    logic [CNT_W-1:0]      corner_col;
    logic [VALUE_BITS-1:0] corner_delta;
    logic                  corner_ok;
    logic [ADDR_W-1:0]     corner_addr;

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:
            begin
                corner_row   = r_lo_reg;
                corner_col   = c_lo_reg;
                corner_delta = amount_reg;
            end
            2'd1:
            begin
                corner_row   = r_hi_reg;
                corner_col   = c_hi_reg;
                corner_delta = amount_reg;
            end
            2'd2:
            begin
                corner_row   = r_lo_reg;
                corner_col   = c_hi_reg;
                corner_delta = VALUE_BITS'(0) - amount_reg;
            end
            default:
            begin
                corner_row   = r_hi_reg;
                corner_col   = c_lo_reg;
                corner_delta = VALUE_BITS'(0) - amount_reg;
            end
        endcase
    end

    // Corners past the configured edge are dropped
    assign corner_ok   = (corner_row < row_count_reg) && (corner_col < column_count_reg);
    assign corner_addr = cell_addr(corner_row[ROW_W-1:0], corner_col[COL_W-1:0]);

    // Read-pass helpers
    logic [ADDR_W-1:0]     cur_addr;
    logic [ADDR_W-1:0]     up_addr;
    logic [VALUE_BITS-1:0] cell_sum;
    logic                  row_end;
    logic                  last_row;

    assign cur_addr = cell_addr(read_row_reg, read_col_reg);
    assign up_addr  = cell_addr(read_row_reg - ROW_W'(1), read_col_reg);
    assign cell_sum = cur_reg + up_reg + left_prefix_reg - upper_left_reg;
    assign row_end  = (CNT_W'(read_col_reg) + CNT_W'(1)) >= column_count_reg;
    assign last_row = (CNT_W'(read_row_reg) + CNT_W'(1)) >= row_count_reg;

    // RAM read address
    always_comb
    begin
        unique case (state_reg)
            ST_UPDATE:   ram_raddr = corner_addr;
            ST_READ_CUR: ram_raddr = up_addr;
            default:     ram_raddr = cur_addr;
        endcase
    end

    // Next state and datapath
    always_comb
    begin
        state_next        = state_reg;
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        read_row_next     = read_row_reg;
        read_col_next     = read_col_reg;
        reading_next      = reading_reg;
        left_prefix_next  = left_prefix_reg;
        upper_left_next   = upper_left_reg;
        cur_next          = cur_reg;
        up_next           = up_reg;
        r_lo_next         = r_lo_reg;
        r_hi_next         = r_hi_reg;
        c_lo_next         = c_lo_reg;
        c_hi_next         = c_hi_reg;
        amount_next       = amount_reg;
        step_next         = step_reg;
        wr_en_next        = wr_en_reg;
        wr_addr_next      = wr_addr_reg;
        wr_delta_next     = wr_delta_reg;
        clr_next          = clr_reg;
        out_valid_next    = out_valid_reg & ~m_tready;
        out_value_next    = out_value_reg;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        out_last_next     = out_last_reg;
        ram_we            = 1'b0;
        ram_waddr         = clr_reg;
        ram_wdata         = '0;

        // Register writes, ignored during a read pass
        if (cfg_valid && !reading_reg)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:
                    row_count_next = clamp_count(cfg_data, CNT_W'(MAX_ROWS));
                REG_COLUMN_COUNT:
                    column_count_next = clamp_count(cfg_data, CNT_W'(MAX_COLS));
                default:
                    ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    r_lo_next   = CNT_W'(in_top_row);
                    c_lo_next   = CNT_W'(in_left_col);
                    amount_next = in_amount;
                    step_next   = '0;
                    wr_en_next  = 1'b0;
                    case (s_tuser)
                        FUNC_LOAD:
                        begin
                            r_hi_next = CNT_W'(in_top_row) + CNT_W'(1);
                            c_hi_next = CNT_W'(in_left_col) + CNT_W'(1);
                            if (!reading_reg &&
                                CNT_W'(in_top_row) < row_count_reg &&
                                CNT_W'(in_left_col) < column_count_reg)
                            begin
                                state_next = ST_UPDATE;
                            end
                        end
                        FUNC_RANGE_ADD:
                        begin
                            r_hi_next = CNT_W'(in_bottom_row) + CNT_W'(1);
                            c_hi_next = CNT_W'(in_right_col) + CNT_W'(1);
                            if (!reading_reg &&
                                in_top_row <= in_bottom_row &&
                                in_left_col <= in_right_col &&
                                CNT_W'(in_bottom_row) < row_count_reg &&
                                CNT_W'(in_right_col) < column_count_reg)
                            begin
                                state_next = ST_UPDATE;
                            end
                        end
                        FUNC_READ:
                        begin
                            // Current cell read issued this cycle
                            reading_next = 1'b1;
                            state_next   = ST_READ_CUR;
                        end
                        default:
                            ;
                    endcase
                end
            end

            ST_UPDATE:
            begin
                // Read corner k while writing back corner k-1
                if (step_reg != '0 && wr_en_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = ram_rdata + wr_delta_reg;
                end
                if (step_reg == STEP_W'(CORNERS))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    wr_en_next    = corner_ok;
                    wr_addr_next  = corner_addr;
                    wr_delta_next = corner_delta;
                    step_next     = step_reg + STEP_W'(1);
                end
            end

            ST_READ_CUR:
            begin
                cur_next   = ram_rdata;
                state_next = ST_READ_UP;
            end

            ST_READ_UP:
            begin
                up_next    = (read_row_reg != '0) ? ram_rdata : '0;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                // Wait until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = cur_addr;
                    ram_wdata      = cell_sum;
                    out_valid_next = 1'b1;
                    out_value_next = cell_sum;
                    out_row_next   = read_row_reg;
                    out_col_next   = read_col_reg;
                    out_last_next  = row_end && last_row;
                    if (row_end && last_row)
                    begin
                        reading_next     = 1'b0;
                        read_row_next    = '0;
                        read_col_next    = '0;
                        left_prefix_next = '0;
                        upper_left_next  = '0;
                        clr_next         = '0;
                        state_next       = ST_CLEAR;
                    end
                    else if (row_end)
                    begin
                        read_col_next    = '0;
                        read_row_next    = read_row_reg + ROW_W'(1);
                        left_prefix_next = '0;
                        upper_left_next  = '0;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        read_col_next    = read_col_reg + COL_W'(1);
                        left_prefix_next = cell_sum;
                        upper_left_next  = up_reg;
                        state_next       = ST_IDLE;
                    end
                end
            end

            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            row_count_reg    <= CNT_W'(MAX_ROWS);
            column_count_reg <= CNT_W'(MAX_COLS);
            read_row_reg     <= '0;
            read_col_reg     <= '0;
            reading_reg      <= 1'b0;
            left_prefix_reg  <= '0;
            upper_left_reg   <= '0;
            step_reg         <= '0;
            wr_en_reg        <= 1'b0;
            clr_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            read_row_reg     <= read_row_next;
            read_col_reg     <= read_col_next;
            reading_reg      <= reading_next;
            left_prefix_reg  <= left_prefix_next;
            upper_left_reg   <= upper_left_next;
            step_reg         <= step_next;
            wr_en_reg        <= wr_en_next;
            clr_reg          <= clr_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        up_reg        <= up_next;
        r_lo_reg      <= r_lo_next;
        r_hi_reg      <= r_hi_next;
        c_lo_reg      <= c_lo_next;
        c_hi_reg      <= c_hi_next;
        amount_reg    <= amount_next;
        wr_addr_reg   <= wr_addr_next;
        wr_delta_reg  <= wr_delta_next;
        out_value_reg <= out_value_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_last_reg  <= out_last_next;
    end

    // Ports
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {4'b0000, out_col_reg, out_row_reg, out_value_reg};

endmodule
